@@ hdl/cfcpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcpp_pkg
// Types and constants shared by the class file constant pool parser.
// ----------------------------------------------------------------------------
package cfcpp_pkg;

    // Header layout and defaults
    localparam logic [31:0] MAGIC_WORD      = 32'hCAFE_BABE;
    localparam logic [15:0] DEFAULT_MAJOR   = 16'd52;
    localparam logic [3:0]  HDR_MAGIC_END   = 4'd3;
    localparam logic [3:0]  HDR_VERSION_END = 4'd7;
    localparam logic [3:0]  HDR_COUNT_END   = 4'd9;

    // Constant pool tags
    localparam logic [7:0] TAG_UTF8         = 8'd1;
    localparam logic [7:0] TAG_INTEGER      = 8'd3;
    localparam logic [7:0] TAG_FLOAT        = 8'd4;
    localparam logic [7:0] TAG_LONG         = 8'd5;
    localparam logic [7:0] TAG_DOUBLE       = 8'd6;
    localparam logic [7:0] TAG_CLASS        = 8'd7;
    localparam logic [7:0] TAG_STRING       = 8'd8;
    localparam logic [7:0] TAG_FIELDREF     = 8'd9;
    localparam logic [7:0] TAG_METHODREF    = 8'd10;
    localparam logic [7:0] TAG_IFACE_METHOD = 8'd11;
    localparam logic [7:0] TAG_NAME_TYPE    = 8'd12;
    localparam logic [7:0] TAG_METHOD_HNDL  = 8'd15;
    localparam logic [7:0] TAG_METHOD_TYPE  = 8'd16;
    localparam logic [7:0] TAG_INVOKE_DYN   = 8'd18;

    // Payload sizes skipped after the tag byte
    localparam logic [15:0] SIZE_INDEX2     = 16'd2;
    localparam logic [15:0] SIZE_HANDLE     = 16'd3;
    localparam logic [15:0] SIZE_WORD       = 16'd4;
    localparam logic [15:0] SIZE_WIDE       = 16'd8;

    // Event kinds
    localparam logic [2:0] EV_HEADER_OK    = 3'd0;
    localparam logic [2:0] EV_BAD_MAGIC    = 3'd1;
    localparam logic [2:0] EV_BAD_VERSION  = 3'd2;
    localparam logic [2:0] EV_ENTRY_DONE   = 3'd3;
    localparam logic [2:0] EV_UNKNOWN_TAG  = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TAG,
        PH_FIELD,
        PH_SKIP,
        PH_DONE,
        PH_HALT
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  entry_tag;
        logic [15:0] entry_value;
        logic [15:0] entry_index;
        logic        last;
    } t_out_item;

    // Result of one parse step handed to the output register
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_event;

endpackage

@@ hdl/cfcpp_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcpp_step
// Parser state and the single-byte step: header check, tag decode,
// field assembly and payload skip. State advances on each accepted byte.
// ----------------------------------------------------------------------------
module cfcpp_step
    import cfcpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  logic [15:0] i_required_major,
    output t_event      o_event
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_hdr_count, n_hdr_count;
    logic [31:0] r_shift, n_shift;
    logic [15:0] r_pool_count, n_pool_count;
    logic [15:0] r_slot, n_slot;
    logic [15:0] r_skip, n_skip;
    logic [7:0]  r_tag, n_tag;

    // Effective state after an optional restart
    t_phase      e_phase;
    logic [3:0]  e_hdr_count;
    logic [31:0] e_shift;
    logic [15:0] e_pool_count, e_slot, e_skip;
    logic [7:0]  e_tag, b;

    logic [31:0] hdr_shift;
    logic [15:0] fld_shift;
    logic [15:0] skip_dec;
    logic        tag_known, tag_is_field;
    logic [15:0] tag_size;
    logic [16:0] fin_next;
    logic        fin_last;
    logic        magic_bad, version_bad, count_small;
    logic        fld_utf8_body;

    assign b = i_item.data_byte;

    // Restart clears the parse state before the byte is used
    always_comb begin
        if (i_item.start_of_file) begin
            e_phase      = PH_HEADER;
            e_hdr_count  = '0;
            e_shift      = '0;
            e_pool_count = '0;
            e_slot       = '0;
            e_skip       = '0;
            e_tag        = '0;
        end else begin
            e_phase      = r_phase;
            e_hdr_count  = r_hdr_count;
            e_shift      = r_shift;
            e_pool_count = r_pool_count;
            e_slot       = r_slot;
            e_skip       = r_skip;
            e_tag        = r_tag;
        end
    end

    // Shared datapath terms
    assign hdr_shift     = {e_shift[23:0], b};
    assign fld_shift     = {e_shift[7:0], b};
    assign skip_dec      = e_skip - 16'd1;
    assign magic_bad     = (e_hdr_count == HDR_MAGIC_END) && (hdr_shift != MAGIC_WORD);
    assign version_bad   = (e_hdr_count == HDR_VERSION_END)
                           && (hdr_shift[15:0] != i_required_major);
    assign count_small   = (hdr_shift[15:0] <= 16'd1);
    assign fld_utf8_body = (e_tag == TAG_UTF8) && (fld_shift != 16'd0);

    // Entry completion: wide entries take two slots
    assign fin_next = {1'b0, e_slot}
                      + ((e_tag == TAG_LONG || e_tag == TAG_DOUBLE) ? 17'd2 : 17'd1);
    assign fin_last = (fin_next >= {1'b0, e_pool_count});

    // Decode the tag byte
    always_comb begin
        tag_known    = 1'b1;
        tag_is_field = 1'b0;
        tag_size     = SIZE_INDEX2;
        unique case (b)
            TAG_UTF8, TAG_CLASS: begin
                tag_is_field = 1'b1;
                tag_size     = SIZE_INDEX2;
            end
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
            TAG_IFACE_METHOD, TAG_NAME_TYPE, TAG_INVOKE_DYN: begin
                tag_size = SIZE_WORD;
            end
            TAG_LONG, TAG_DOUBLE: begin
                tag_size = SIZE_WIDE;
            end
            TAG_STRING, TAG_METHOD_TYPE: begin
                tag_size = SIZE_INDEX2;
            end
            TAG_METHOD_HNDL: begin
                tag_size = SIZE_HANDLE;
            end
            default: begin
                tag_known = 1'b0;
            end
        endcase
    end

    // Next phase
    always_comb begin
        n_phase = e_phase;
        unique case (e_phase)
            PH_HEADER: begin
                if (magic_bad || version_bad) begin
                    n_phase = PH_HALT;
                end else if (e_hdr_count == HDR_COUNT_END) begin
                    n_phase = count_small ? PH_DONE : PH_TAG;
                end
            end
            PH_TAG: begin
                if (!tag_known) begin
                    n_phase = PH_HALT;
                end else begin
                    n_phase = tag_is_field ? PH_FIELD : PH_SKIP;
                end
            end
            PH_FIELD: begin
                if (skip_dec == 16'd0) begin
                    if (fld_utf8_body) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_phase = fin_last ? PH_DONE : PH_TAG;
                    end
                end
            end
            PH_SKIP: begin
                if (skip_dec == 16'd0) begin
                    n_phase = fin_last ? PH_DONE : PH_TAG;
                end
            end
            PH_DONE, PH_HALT: begin
                n_phase = e_phase;
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase
    end

    // Next datapath registers
    always_comb begin
        n_hdr_count  = e_hdr_count;
        n_shift      = e_shift;
        n_pool_count = e_pool_count;
        n_slot       = e_slot;
        n_skip       = e_skip;
        n_tag        = e_tag;
        case (e_phase)
            PH_HEADER: begin
                n_shift     = hdr_shift;
                n_hdr_count = e_hdr_count + 4'd1;
                if (!magic_bad && !version_bad && e_hdr_count == HDR_COUNT_END) begin
                    n_pool_count = hdr_shift[15:0];
                    n_shift      = '0;
                    if (!count_small) begin
                        n_slot = 16'd1;
                    end
                end
            end
            PH_TAG: begin
                n_tag   = b;
                n_shift = '0;
                if (tag_known) begin
                    n_skip = tag_size;
                end
            end
            PH_FIELD: begin
                n_shift = {16'd0, fld_shift};
                n_skip  = skip_dec;
                if (skip_dec == 16'd0) begin
                    if (fld_utf8_body) begin
                        n_skip = fld_shift;
                    end else if (!fin_last) begin
                        n_slot = fin_next[15:0];
                    end
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0 && !fin_last) begin
                    n_slot = fin_next[15:0];
                end
            end
            default: begin
                n_skip = e_skip;
            end
        endcase
    end

    // Result of this byte
    always_comb begin
        o_event       = '0;
        case (e_phase)
            PH_HEADER: begin
                if (magic_bad) begin
                    o_event.valid           = 1'b1;
                    o_event.item.event_kind = EV_BAD_MAGIC;
                end else if (version_bad) begin
                    o_event.valid           = 1'b1;
                    o_event.item.event_kind = EV_BAD_VERSION;
                end else if (e_hdr_count == HDR_COUNT_END) begin
                    o_event.valid            = 1'b1;
                    o_event.item.event_kind  = EV_HEADER_OK;
                    o_event.item.entry_value = hdr_shift[15:0];
                    o_event.item.last        = count_small;
                end
            end
            PH_TAG: begin
                if (!tag_known) begin
                    o_event.valid            = 1'b1;
                    o_event.item.event_kind  = EV_UNKNOWN_TAG;
                    o_event.item.entry_tag   = b;
                    o_event.item.entry_index = e_slot;
                end
            end
            PH_FIELD: begin
                if (skip_dec == 16'd0 && !fld_utf8_body) begin
                    o_event.valid            = 1'b1;
                    o_event.item.event_kind  = EV_ENTRY_DONE;
                    o_event.item.entry_tag   = e_tag;
                    o_event.item.entry_value = fld_shift;
                    o_event.item.entry_index = e_slot;
                    o_event.item.last        = fin_last;
                end
            end
            PH_SKIP: begin
                if (skip_dec == 16'd0) begin
                    o_event.valid            = 1'b1;
                    o_event.item.event_kind  = EV_ENTRY_DONE;
                    o_event.item.entry_tag   = e_tag;
                    o_event.item.entry_value = (e_tag == TAG_UTF8) ? e_shift[15:0] : 16'd0;
                    o_event.item.entry_index = e_slot;
                    o_event.item.last        = fin_last;
                end
            end
            default: begin
                o_event.valid = 1'b0;
            end
        endcase
    end

    // Advance the parse state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_count  <= '0;
            r_shift      <= '0;
            r_pool_count <= '0;
            r_slot       <= '0;
            r_skip       <= '0;
            r_tag        <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_hdr_count  <= n_hdr_count;
            r_shift      <= n_shift;
            r_pool_count <= n_pool_count;
            r_slot       <= n_slot;
            r_skip       <= n_skip;
            r_tag        <= n_tag;
        end
    end

endmodule

@@ hdl/cfcpp_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcpp_out_reg
// Result register: holds one event until the receiver takes it.
// ----------------------------------------------------------------------------
module cfcpp_out_reg
    import cfcpp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_item,
    input  logic      i_ready,
    output logic      o_valid,
    output t_out_item o_item
);

    logic      r_valid, n_valid;
    t_out_item r_item;

    // Load a new event, or drop the current one once taken
    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the payload until the next load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hdl/class_file_constant_pool_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_file_constant_pool_parser
// Walks the header and constant pool of a class file fed one byte per
// transaction, reporting header status and one event per pool entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one file
//   byte per transaction; start_of_file restarts parsing at that byte.
//   Output channel (o_out_valid / i_out_ready / o_out_item) carries at most
//   one event per byte: header ok, bad magic, bad version, entry done or
//   unknown tag.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
//   the required major version; it is always ready. Write it only while idle.
// Timing:
//   One byte per cycle sustained while no event is stalled. An event sits in the
//   output register in the cycle after its byte is accepted. The step logic
//   between the parse state registers and the output register is combinational.
// Reset:
//   Synchronous, active low. Parsing restarts at file byte 0 and the
//   required major version returns to 52. No event is pending.
// Stall:
//   While a pending event is not taken, o_in_ready is low and no byte is
//   consumed; bytes flow again in the cycle the receiver takes the event.
// ----------------------------------------------------------------------------
module class_file_constant_pool_parser
    import cfcpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    // event output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_required_major;
    logic        in_accept;
    t_event      step_event;

    // Accept a byte whenever the output register is free or being emptied
    assign o_in_ready  = !o_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_required_major <= DEFAULT_MAJOR;
        end else if (i_cfg_valid) begin
            r_required_major <= i_cfg_data;
        end
    end

    cfcpp_step u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_item           (i_in_item),
        .i_required_major (r_required_major),
        .o_event          (step_event)
    );

    cfcpp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_accept && step_event.valid),
        .i_item  (step_event.item),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    // A stalled event blocks further input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while an event is stalled");

    // A header that ends the pool carries a count of zero or one
    a_header_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_kind == EV_HEADER_OK && o_out_item.last
        |-> o_out_item.entry_value <= 16'd1)
        else $error("header end-of-pool with count above one");

    // Header errors never end the pool and carry no slot
    a_header_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.event_kind == EV_BAD_MAGIC ||
                        o_out_item.event_kind == EV_BAD_VERSION)
        |-> !o_out_item.last && o_out_item.entry_index == 16'd0)
        else $error("header error with slot or last set");

    // Finished entries always sit in a slot from one upward
    a_entry_slot_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_kind == EV_ENTRY_DONE
        |-> o_out_item.entry_index != 16'd0)
        else $error("entry reported at slot zero");
`endif

endmodule

@@ verif/tb_class_file_constant_pool_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_class_file_constant_pool_parser
// Self-checking bench for the class file constant pool parser. A short table
// of hand-written files opens the run. Random class files follow, mostly
// well-formed with random content, plus corrupted headers, unknown tags,
// truncated pools and byte noise, under several major version settings.
// Every accepted byte goes through a local parser model. Every event leaving
// the block is compared field by field with the oldest predicted event.
// ----------------------------------------------------------------------------
module tb_class_file_constant_pool_parser;
    import cfcpp_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int PHASE_BYTES     = 280;
    localparam int NUM_PHASES      = 5;
    localparam int NUM_DIRECTED    = 28;

    localparam logic      PREDICT  = 1'b0;
    localparam logic      TYPED    = 1'b1;
    localparam t_out_item NO_EVENT = '0;

    // One row of the directed table: a byte and, where obvious, its event
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item ev;
    } t_vector;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = '0;

    // Expectation attached to the byte currently offered
    logic        row_typed   = 1'b0;
    t_out_item   row_event   = '0;
    logic        steady      = 1'b0;

    t_out_item   expected_events[$];
    t_in_item    file_stream[$];
    t_vector     directed_rows [NUM_DIRECTED];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    // Local parser model state
    t_phase      pool_phase;
    logic [3:0]  hdr_bytes;
    logic [31:0] field_acc;
    logic [15:0] pool_count;
    logic [15:0] slot;
    logic [15:0] bytes_left;
    logic [7:0]  cur_tag;
    logic [15:0] major_cfg;

    class_file_constant_pool_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Payload length after the tag byte; zero marks an unknown tag
    function automatic logic [15:0] payload_bytes(input logic [7:0] tag);
        case (tag)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: return SIZE_INDEX2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
            TAG_IFACE_METHOD, TAG_NAME_TYPE, TAG_INVOKE_DYN:  return SIZE_WORD;
            TAG_LONG, TAG_DOUBLE:                             return SIZE_WIDE;
            TAG_METHOD_HNDL:                                  return SIZE_HANDLE;
            default:                                          return 16'd0;
        endcase
    endfunction

    function automatic logic [7:0] known_tag(input int k);
        case (k)
            0:       return TAG_UTF8;
            1:       return TAG_INTEGER;
            2:       return TAG_FLOAT;
            3:       return TAG_LONG;
            4:       return TAG_DOUBLE;
            5:       return TAG_CLASS;
            6:       return TAG_STRING;
            7:       return TAG_FIELDREF;
            8:       return TAG_METHODREF;
            9:       return TAG_IFACE_METHOD;
            10:      return TAG_NAME_TYPE;
            11:      return TAG_METHOD_HNDL;
            12:      return TAG_METHOD_TYPE;
            default: return TAG_INVOKE_DYN;
        endcase
    endfunction

    task automatic restart_parse();
        pool_phase = PH_HEADER;
        hdr_bytes  = '0;
        field_acc  = '0;
        pool_count = '0;
        slot       = '0;
        bytes_left = '0;
        cur_tag    = '0;
    endtask

    // Close the current entry and advance to the next slot or to the end
    function automatic t_out_item close_entry(input logic [15:0] value);
        logic [16:0] next_slot;
        t_out_item   ev;
        next_slot = {1'b0, slot} +
                    ((cur_tag == TAG_LONG || cur_tag == TAG_DOUBLE) ? 17'd2 : 17'd1);
        ev = '{EV_ENTRY_DONE, cur_tag, value, slot, next_slot >= {1'b0, pool_count}};
        if (ev.last) begin
            pool_phase = PH_DONE;
        end else begin
            slot       = next_slot[15:0];
            pool_phase = PH_TAG;
        end
        return ev;
    endfunction

    // Advance the model by one byte; fire marks an event
    task automatic parse_step(input t_in_item it, output logic fire, output t_out_item ev);
        logic [3:0]  n;
        logic [15:0] size;
        fire = 1'b0;
        ev   = NO_EVENT;
        if (it.start_of_file)
            restart_parse();
        case (pool_phase)
            PH_HEADER: begin
                field_acc = {field_acc[23:0], it.data_byte};
                n         = hdr_bytes;
                hdr_bytes = hdr_bytes + 4'd1;
                if (n == HDR_MAGIC_END && field_acc != MAGIC_WORD) begin
                    pool_phase    = PH_HALT;
                    fire          = 1'b1;
                    ev.event_kind = EV_BAD_MAGIC;
                end else if (n == HDR_VERSION_END && field_acc[15:0] != major_cfg) begin
                    pool_phase    = PH_HALT;
                    fire          = 1'b1;
                    ev.event_kind = EV_BAD_VERSION;
                end else if (n == HDR_COUNT_END) begin
                    pool_count     = field_acc[15:0];
                    field_acc      = '0;
                    fire           = 1'b1;
                    ev.event_kind  = EV_HEADER_OK;
                    ev.entry_value = pool_count;
                    if (pool_count <= 16'd1) begin
                        pool_phase = PH_DONE;
                        ev.last    = 1'b1;
                    end else begin
                        slot       = 16'd1;
                        pool_phase = PH_TAG;
                    end
                end
            end
            PH_TAG: begin
                cur_tag   = it.data_byte;
                field_acc = '0;
                size      = payload_bytes(it.data_byte);
                if (it.data_byte == TAG_UTF8 || it.data_byte == TAG_CLASS) begin
                    bytes_left = SIZE_INDEX2;
                    pool_phase = PH_FIELD;
                end else if (size == 16'd0) begin
                    pool_phase = PH_HALT;
                    fire       = 1'b1;
                    ev         = '{EV_UNKNOWN_TAG, it.data_byte, 16'd0, slot, 1'b0};
                end else begin
                    bytes_left = size;
                    pool_phase = PH_SKIP;
                end
            end
            PH_FIELD: begin
                field_acc  = {16'h0000, field_acc[7:0], it.data_byte};
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) begin
                    if (cur_tag == TAG_UTF8 && field_acc[15:0] != 16'd0) begin
                        bytes_left = field_acc[15:0];
                        pool_phase = PH_SKIP;
                    end else begin
                        fire = 1'b1;
                        ev   = close_entry(field_acc[15:0]);
                    end
                end
            end
            PH_SKIP: begin
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) begin
                    fire = 1'b1;
                    ev   = close_entry(cur_tag == TAG_UTF8 ? field_acc[15:0] : 16'd0);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
    endtask

    task automatic check_event(input t_out_item got, input t_out_item want);
        if (got.event_kind != want.event_kind)
            report_mismatch("event_kind", 64'(got.event_kind), 64'(want.event_kind));
        if (got.entry_tag != want.entry_tag)
            report_mismatch("entry_tag", 64'(got.entry_tag), 64'(want.entry_tag));
        if (got.entry_value != want.entry_value)
            report_mismatch("entry_value", 64'(got.entry_value), 64'(want.entry_value));
        if (got.entry_index != want.entry_index)
            report_mismatch("entry_index", 64'(got.entry_index), 64'(want.entry_index));
        if (got.last != want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
    endtask

    // Check leaving events, then predict from the byte taken at this edge
    always @(posedge i_clk) begin
        logic      fire;
        t_out_item ev;
        if (!i_rst_n) begin
            restart_parse();
            major_cfg = DEFAULT_MAJOR;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_events.size() == 0)
                    report_mismatch("event with none pending", 64'(o_out_item), 64'd0);
                else
                    check_event(o_out_item, expected_events.pop_front());
            end
            if (i_cfg_valid && o_cfg_ready)
                major_cfg = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                parse_step(i_in_item, fire, ev);
                if (row_typed)
                    expected_events = {expected_events, row_event};
                else if (fire)
                    expected_events = {expected_events, ev};
            end
        end
    end

    // Stall the event channel at random, except in the steady stretch
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 19);
    end

    // End the run when no transaction of any kind moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte, idling at random first, and hold it until accepted
    task automatic put_byte(input t_in_item item, input logic typed, input t_out_item ev);
        while (!steady && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        row_typed  <= typed;
        row_event  <= ev;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Hold the byte channel until every predicted event has left
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_events.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_major(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic s);
        file_stream = {file_stream, t_in_item'{b, s}};
    endtask

    // Build one random file: mostly well-formed, sometimes broken or noise
    task automatic compose_file(input logic [15:0] major);
        int          n;
        int          cap;
        int          pick;
        logic [16:0] slot_n;
        logic [15:0] count;
        logic [15:0] ver;
        logic [15:0] len;
        logic [31:0] magic;
        logic [7:0]  tag;
        logic        s0;
        file_stream.delete();
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 12))
                push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end else begin
            magic = MAGIC_WORD;
            if ($urandom_range(19) == 0)
                magic = magic ^ (32'd1 << $urandom_range(31));
            ver = major;
            if ($urandom_range(9) == 0)
                ver = ver ^ (16'd1 << $urandom_range(15));
            pick = int'($urandom_range(99));
            if (pick < 8)
                count = 16'($urandom_range(1));
            else if (pick < 80)
                count = 16'($urandom_range(2, 8));
            else if (pick < 90)
                count = 16'($urandom_range(9, 30));
            else
                count = 16'($urandom_range(65535));
            cap = ($urandom_range(9) == 0) ? int'($urandom_range(0, 3)) : 14;
            s0  = ($urandom_range(19) != 0);

            // Header: magic, minor, major, pool count
            push_byte(magic[31:24], s0);
            push_byte(magic[23:16], 1'b0);
            push_byte(magic[15:8], 1'b0);
            push_byte(magic[7:0], 1'b0);
            push_byte(8'($urandom_range(255)), 1'b0);
            push_byte(8'($urandom_range(255)), 1'b0);
            push_byte(ver[15:8], 1'b0);
            push_byte(ver[7:0], 1'b0);
            push_byte(count[15:8], 1'b0);
            push_byte(count[7:0], 1'b0);

            // Pool entries with random payloads
            slot_n = 17'd1;
            n      = 0;
            while (slot_n < {1'b0, count} && n < cap) begin
                if ($urandom_range(24) == 0) begin
                    do
                        tag = 8'($urandom_range(255));
                    while (payload_bytes(tag) != 16'd0);
                    push_byte(tag, 1'b0);
                    n = cap;
                end else begin
                    tag = known_tag(int'($urandom_range(13)));
                    push_byte(tag, 1'b0);
                    if (tag == TAG_UTF8) begin
                        len = ($urandom_range(9) == 0) ? 16'($urandom_range(20, 60))
                                                       : 16'($urandom_range(0, 6));
                        push_byte(len[15:8], 1'b0);
                        push_byte(len[7:0], 1'b0);
                        repeat (len)
                            push_byte(8'($urandom_range(255)), 1'b0);
                    end else begin
                        repeat (payload_bytes(tag))
                            push_byte(8'($urandom_range(255)), 1'b0);
                    end
                    slot_n = slot_n + ((tag == TAG_LONG || tag == TAG_DOUBLE) ? 17'd2 : 17'd1);
                    n++;
                end
            end

            // Trailing bytes past the pool
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 3))
                    push_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    initial begin
        int          p;
        int unsigned sent;
        logic [15:0] major;

        // Reset value check, trailing byte, bad magic, zero-length Utf8
        directed_rows = '{
            '{'{8'hCA, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'hFE, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'hBA, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'hBE, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h00, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h00, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h00, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h34, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h00, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h01, 1'b0}, TYPED,   '{EV_HEADER_OK, 8'h00, 16'd1, 16'd0, 1'b1}},
            '{'{8'hFF, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'hFF, 1'b1}, PREDICT, NO_EVENT},
            '{'{8'hFF, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'hFF, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'hFF, 1'b0}, TYPED,   '{EV_BAD_MAGIC, 8'h00, 16'd0, 16'd0, 1'b0}},
            '{'{8'hCA, 1'b1}, PREDICT, NO_EVENT},
            '{'{8'hFE, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'hBA, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'hBE, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'hFF, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'hFF, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h00, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h34, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h00, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h02, 1'b0}, TYPED,   '{EV_HEADER_OK, 8'h00, 16'd2, 16'd0, 1'b0}},
            '{'{TAG_UTF8, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h00, 1'b0}, PREDICT, NO_EVENT},
            '{'{8'h00, 1'b0}, TYPED,   '{EV_ENTRY_DONE, TAG_UTF8, 16'd0, 16'd1, 1'b1}}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < NUM_DIRECTED; i++)
            put_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].ev);

        // Random files under several major version settings
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            case (p)
                0:       major = 16'h0000;
                1:       major = 16'hFFFF;
                3:       major = DEFAULT_MAJOR;
                default: major = 16'($urandom_range(65535));
            endcase
            write_major(major);
            steady <= (p == 2);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                compose_file(major);
                foreach (file_stream[i])
                    put_byte(file_stream[i], PREDICT, NO_EVENT);
                sent += 32'(file_stream.size());
                if ($urandom_range(99) < 3)
                    wait_drained();
            end
        end

        // Drain and give the block time to show any stray event
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_events.size() != 0)
            report_mismatch("events still owed at end", 64'(expected_events.size()), 64'd0);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/cfcpp_pkg.sv
hdl/cfcpp_step.sv
hdl/cfcpp_out_reg.sv
hdl/class_file_constant_pool_parser.sv
verif/tb_class_file_constant_pool_parser.sv
